/* src/assert_macros.svh */
// assertion macros shared by the admission control rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UAC_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define UAC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define UAC_ASSERT(label, clk, rst, expr)
`define UAC_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif
`endif

/* src/uac_pkg.sv */
// types, constants and microcode table for the admission control block
// no dependencies
package uac_pkg;

   localparam int unsigned DATA_W              = 40;
   localparam int unsigned STATUS_W            = 3;
   localparam int unsigned GRANULARITY_DEFAULT = 1000000;

   localparam int unsigned PROG_LEN = 10;
   localparam int unsigned PC_W     = $clog2(PROG_LEN);

   typedef logic [PC_W-1:0] uac_pc_type;

   localparam uac_pc_type PC_FETCH    = PC_W'(0);
   localparam uac_pc_type PC_DISPATCH = PC_W'(1);
   localparam uac_pc_type PC_CHECK_DL = PC_W'(2);
   localparam uac_pc_type PC_MUL      = PC_W'(3);
   localparam uac_pc_type PC_DIV      = PC_W'(4);
   localparam uac_pc_type PC_ADMIT    = PC_W'(5);
   localparam uac_pc_type PC_RELEASE  = PC_W'(6);
   localparam uac_pc_type PC_ZERO_DL  = PC_W'(7);
   localparam uac_pc_type PC_EMIT     = PC_W'(8);
   localparam uac_pc_type PC_RETURN   = PC_W'(9);

   typedef enum logic [STATUS_W-1:0] {
      ST_ADMITTED      = 3'd0,
      ST_REFUSED       = 3'd1,
      ST_RELEASED      = 3'd2,
      ST_ZERO_DEADLINE = 3'd3,
      ST_ZERO_ESTIMATE = 3'd4,
      ST_UNDERFLOW     = 3'd5
   } uac_status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_FETCH,
      OP_MUL,
      OP_DIV,
      OP_ADMIT,
      OP_RELEASE,
      OP_ZERO_DL,
      OP_EMIT
   } uac_op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_IS_RELEASE,
      COND_DL_ZERO,
      COND_CNT_MORE,
      COND_OUT_BUSY
   } uac_cond_type;

   typedef struct packed {
      uac_op_type   op;
      uac_cond_type cond;
      uac_pc_type   target;
   } uac_uword_type;

   typedef struct packed {
      logic no_req;
      logic is_release;
      logic dl_zero;
      logic cnt_more;
      logic out_busy;
   } uac_flags_type;

   function automatic uac_uword_type ucode_word(input uac_pc_type pc);
      uac_uword_type w;
      unique case (pc)
         PC_FETCH:    w = '{OP_FETCH,   COND_NO_REQ,     PC_FETCH};
         PC_DISPATCH: w = '{OP_NONE,    COND_IS_RELEASE, PC_RELEASE};
         PC_CHECK_DL: w = '{OP_NONE,    COND_DL_ZERO,    PC_ZERO_DL};
         PC_MUL:      w = '{OP_MUL,     COND_NEXT,       PC_FETCH};
         PC_DIV:      w = '{OP_DIV,     COND_CNT_MORE,   PC_DIV};
         PC_ADMIT:    w = '{OP_ADMIT,   COND_ALWAYS,     PC_EMIT};
         PC_RELEASE:  w = '{OP_RELEASE, COND_ALWAYS,     PC_EMIT};
         PC_ZERO_DL:  w = '{OP_ZERO_DL, COND_NEXT,       PC_FETCH};
         PC_EMIT:     w = '{OP_EMIT,    COND_OUT_BUSY,   PC_EMIT};
         PC_RETURN:   w = '{OP_NONE,    COND_ALWAYS,     PC_FETCH};
         default:     w = '{OP_NONE,    COND_ALWAYS,     PC_FETCH};
      endcase
      return w;
   endfunction

endpackage

/* src/uac_req_if.sv */
// request channel: valid/ready handshake with the request fields
// depends on uac_pkg
interface uac_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [uac_pkg::DATA_W-1:0]  exec_time;
   logic [uac_pkg::DATA_W-1:0]  deadline;
   logic [uac_pkg::DATA_W-1:0]  release_amount;

   modport source (output valid, req_type, exec_time, deadline, release_amount, input ready);
   modport sink   (input valid, req_type, exec_time, deadline, release_amount, output ready);
endinterface

/* src/uac_rsp_if.sv */
// response channel: valid/ready handshake with the result fields
// depends on uac_pkg
interface uac_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [uac_pkg::STATUS_W-1:0]  status;
   logic [uac_pkg::DATA_W-1:0]    granted_estimate;
   logic [uac_pkg::DATA_W-1:0]    admitted_total;

   modport source (output valid, status, granted_estimate, admitted_total, input ready);
   modport sink   (input valid, status, granted_estimate, admitted_total, output ready);
endinterface

/* src/utilization_admission_control.sv */
// Utilisation-based admission control. Each request is either an admit (exec time and deadline)
// or a completion (release amount) and yields exactly one response. The load estimate is
// floor(exec_time * GRANULARITY / deadline), formed by a constant multiply and a restoring
// divider that retires one quotient bit per cycle over 40 + clog2(GRANULARITY + 1) bits
// (60 at the default granularity). An admit request occupies the block through the multiply and
// the divider loop of the microcode; a zero deadline or a completion skips both. A finished
// response is held in an output register, so the next request is taken while it waits.
// Capacity is written through the csr port; the user must write it only while no request is
// in flight, the block does not enforce this. It resets to zero, refusing every admission.
// depends on uac_pkg, uac_req_if, uac_rsp_if, uac_sequencer and uac_datapath
module utilization_admission_control #(
   parameter int unsigned GRANULARITY = uac_pkg::GRANULARITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [uac_pkg::DATA_W-1:0]  csr_write_data,
   uac_req_if.sink                     req_if,
   uac_rsp_if.source                   rsp_if
);

   uac_pkg::uac_op_type    op;
   uac_pkg::uac_flags_type flags;

   uac_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .op    (op)
   );

   uac_datapath #(
      .GRANULARITY (GRANULARITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .op               (op),
      .flags            (flags),
      .req_if           (req_if),
      .rsp_if           (rsp_if)
   );

endmodule

/* src/uac_sequencer.sv */
// microcode sequencer: step counter, table lookup and conditional jumps
// depends on uac_pkg and assert_macros.svh
`include "assert_macros.svh"

module uac_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  uac_pkg::uac_flags_type flags,
   output uac_pkg::uac_op_type    op
);

   uac_pkg::uac_pc_type    pc_ff;
   uac_pkg::uac_pc_type    pc_in;
   uac_pkg::uac_uword_type uword;
   logic                   take;

   assign uword = uac_pkg::ucode_word(pc_ff);
   assign op    = uword.op;

   always_comb begin
      unique case (uword.cond)
         uac_pkg::COND_NEXT:       take = 1'b0;
         uac_pkg::COND_ALWAYS:     take = 1'b1;
         uac_pkg::COND_NO_REQ:     take = flags.no_req;
         uac_pkg::COND_IS_RELEASE: take = flags.is_release;
         uac_pkg::COND_DL_ZERO:    take = flags.dl_zero;
         uac_pkg::COND_CNT_MORE:   take = flags.cnt_more;
         uac_pkg::COND_OUT_BUSY:   take = flags.out_busy;
         default:                  take = 1'b1;
      endcase
      pc_in = take ? uword.target : pc_ff + uac_pkg::PC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= uac_pkg::PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `UAC_ASSERT(a_pc_in_program, clock, reset, pc_ff < uac_pkg::PC_W'(uac_pkg::PROG_LEN))

endmodule

/* src/uac_datapath.sv */
// datapath: request latch, constant multiply, restoring divider, load sum and result register
// depends on uac_pkg, uac_req_if, uac_rsp_if and assert_macros.svh
`include "assert_macros.svh"

module uac_datapath #(
   parameter int unsigned GRANULARITY = uac_pkg::GRANULARITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [uac_pkg::DATA_W-1:0]  csr_write_data,
   input  uac_pkg::uac_op_type         op,
   output uac_pkg::uac_flags_type      flags,
   uac_req_if.sink                     req_if,
   uac_rsp_if.source                   rsp_if
);

   localparam int unsigned DW    = uac_pkg::DATA_W;
   localparam int unsigned GW    = $clog2(GRANULARITY + 1);
   localparam int unsigned PW    = DW + GW;
   localparam int unsigned CNT_W = $clog2(PW + 1);
   localparam logic [GW-1:0] GRAN_W = GW'(GRANULARITY);

   logic [DW-1:0]           load_ff, load_in;
   logic [DW-1:0]           cap_ff, cap_in;
   logic                    kind_ff, kind_in;
   logic [DW-1:0]           exec_ff, exec_in;
   logic [DW-1:0]           dl_ff, dl_in;
   logic [DW-1:0]           rel_ff, rel_in;
   logic [PW-1:0]           quo_ff, quo_in;
   logic [DW-1:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   uac_pkg::uac_status_type res_status_ff, res_status_in;
   logic [DW-1:0]           res_granted_ff, res_granted_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   uac_pkg::uac_status_type rsp_status_ff, rsp_status_in;
   logic [DW-1:0]           rsp_granted_ff, rsp_granted_in;
   logic [DW-1:0]           rsp_total_ff, rsp_total_in;

   logic [PW-1:0]           product;
   logic [DW:0]             trial;
   logic [PW:0]             sum;
   logic                    out_busy;

   assign product  = PW'(exec_ff) * PW'(GRAN_W);
   assign trial    = {rem_ff, quo_ff[PW-1]};
   assign sum      = (PW+1)'(load_ff) + (PW+1)'(quo_ff);
   assign out_busy = rsp_valid_ff & ~rsp_if.ready;

   assign flags.no_req     = ~req_if.valid;
   assign flags.is_release = kind_ff;
   assign flags.dl_zero    = (dl_ff == '0);
   assign flags.cnt_more   = (cnt_ff != CNT_W'(1));
   assign flags.out_busy   = out_busy;

   assign req_if.ready            = (op == uac_pkg::OP_FETCH) & ~reset;
   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.status           = rsp_status_ff;
   assign rsp_if.granted_estimate = rsp_granted_ff;
   assign rsp_if.admitted_total   = rsp_total_ff;

   always_comb begin
      load_in        = load_ff;
      cap_in         = cap_ff;
      kind_in        = kind_ff;
      exec_in        = exec_ff;
      dl_in          = dl_ff;
      rel_in         = rel_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in   = out_busy;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_total_in   = rsp_total_ff;

      unique case (op)
         uac_pkg::OP_NONE: begin
         end
         uac_pkg::OP_FETCH: begin
            if (req_if.valid) begin
               kind_in = req_if.req_type;
               exec_in = req_if.exec_time;
               dl_in   = req_if.deadline;
               rel_in  = req_if.release_amount;
            end
         end
         uac_pkg::OP_MUL: begin
            quo_in = product;
            rem_in = '0;
            cnt_in = CNT_W'(PW);
         end
         uac_pkg::OP_DIV: begin
            // one restoring step per cycle, quotient shifts in at the bottom
            if (trial >= {1'b0, dl_ff}) begin
               rem_in = DW'(trial - {1'b0, dl_ff});
               quo_in = {quo_ff[PW-2:0], 1'b1};
            end else begin
               rem_in = trial[DW-1:0];
               quo_in = {quo_ff[PW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
         end
         uac_pkg::OP_ADMIT: begin
            res_granted_in = '0;
            if (quo_ff == '0) begin
               res_status_in = uac_pkg::ST_ZERO_ESTIMATE;
            end else if (sum >= (PW+1)'(cap_ff)) begin
               res_status_in = uac_pkg::ST_REFUSED;
            end else begin
               res_status_in  = uac_pkg::ST_ADMITTED;
               res_granted_in = quo_ff[DW-1:0];
               load_in        = sum[DW-1:0];
            end
         end
         uac_pkg::OP_RELEASE: begin
            res_granted_in = '0;
            if (rel_ff > load_ff) begin
               res_status_in = uac_pkg::ST_UNDERFLOW;
            end else begin
               res_status_in = uac_pkg::ST_RELEASED;
               load_in       = load_ff - rel_ff;
            end
         end
         uac_pkg::OP_ZERO_DL: begin
            res_status_in  = uac_pkg::ST_ZERO_DEADLINE;
            res_granted_in = '0;
         end
         uac_pkg::OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_granted_in = res_granted_ff;
               rsp_total_in   = load_ff;
            end
         end
         default: begin
         end
      endcase

      if (csr_write_enable) begin
         cap_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff      <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         load_ff      <= load_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      exec_ff        <= exec_in;
      dl_ff          <= dl_in;
      rel_ff         <= rel_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_total_ff   <= rsp_total_in;
   end

   `UAC_ASSERT_IMPL(a_div_count_live, clock, reset, op == uac_pkg::OP_DIV, cnt_ff != '0)
   `UAC_ASSERT_IMPL(a_total_matches_sum, clock, reset,
      $rose(rsp_valid_ff), rsp_total_ff == load_ff)
   `UAC_ASSERT_IMPL(a_grant_only_admitted, clock, reset,
      rsp_valid_ff && (rsp_status_ff != uac_pkg::ST_ADMITTED), rsp_granted_ff == '0)
   `UAC_ASSERT_IMPL(a_admit_grants_nonzero, clock, reset,
      rsp_valid_ff && (rsp_status_ff == uac_pkg::ST_ADMITTED), rsp_granted_ff != '0)

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench for utilization_admission_control: a directed table, then random request phases
// checked against a behavioural load predictor; depends on uac_pkg, uac_req_if and uac_rsp_if
module testbench;
   import uac_pkg::*;

   localparam int unsigned GRANULARITY = GRANULARITY_DEFAULT;
   localparam int unsigned PHASE_COUNT = 8;
   localparam int unsigned ITEMS_PER_PHASE = 118;
   localparam int unsigned SETTLE_CYCLES = 150;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned PRINT_LIMIT = 50;
   localparam logic [DATA_W-1:0] FULL_SCALE = '1;

   typedef enum logic {
      REQ_ADMIT   = 1'b0,
      REQ_RELEASE = 1'b1
   } request_kind_type;

   typedef enum logic {
      ROW_REQUEST,
      ROW_CAPACITY
   } row_kind_type;

   typedef struct packed {
      request_kind_type   kind;
      logic [DATA_W-1:0]  exec_time;
      logic [DATA_W-1:0]  deadline;
      logic [DATA_W-1:0]  release_amount;
   } load_request_type;

   typedef struct packed {
      uac_status_type     status;
      logic [DATA_W-1:0]  granted;
      logic [DATA_W-1:0]  total;
   } load_outcome_type;

   typedef struct packed {
      row_kind_type       row;
      logic [DATA_W-1:0]  capacity;
      request_kind_type   kind;
      logic [DATA_W-1:0]  exec_time;
      logic [DATA_W-1:0]  deadline;
      logic [DATA_W-1:0]  release_amount;
      logic               typed;
      uac_status_type     status;
      logic [DATA_W-1:0]  granted;
      logic [DATA_W-1:0]  total;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic [DATA_W-1:0] csr_write_data;

   uac_req_if req_bus ();
   uac_rsp_if rsp_bus ();

   utilization_admission_control #(
      .GRANULARITY(GRANULARITY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_if(req_bus),
      .rsp_if(rsp_bus)
   );

   logic [DATA_W-1:0] load_model = '0;
   logic [DATA_W-1:0] capacity_model = '0;
   load_outcome_type pending_outcomes [$];
   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycle_count = 0;

   // first rows assume the reset capacity of zero
   directed_row_type directed_rows [27] = '{
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd1, 40'd1, 40'd0,
        1'b1, ST_REFUSED, 40'd0, 40'd0},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, FULL_SCALE, 40'd0, 40'd0,
        1'b1, ST_ZERO_DEADLINE, 40'd0, 40'd0},
      '{ROW_REQUEST, 40'd0, REQ_RELEASE, 40'd0, 40'd0, 40'd0,
        1'b1, ST_RELEASED, 40'd0, 40'd0},
      '{ROW_REQUEST, 40'd0, REQ_RELEASE, 40'd0, 40'd0, 40'd1,
        1'b1, ST_UNDERFLOW, 40'd0, 40'd0},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd0, 40'd5, 40'd0,
        1'b1, ST_ZERO_ESTIMATE, 40'd0, 40'd0},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd0, 40'd0, 40'd0,
        1'b1, ST_ZERO_DEADLINE, 40'd0, 40'd0},
      '{ROW_CAPACITY, FULL_SCALE, REQ_ADMIT, 40'd0, 40'd0, 40'd0,
        1'b0, ST_ADMITTED, 40'd0, 40'd0},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd1, 40'd1, 40'd0,
        1'b1, ST_ADMITTED, 40'd1000000, 40'd1000000},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd1, 40'd1000001, 40'd0,
        1'b1, ST_ZERO_ESTIMATE, 40'd0, 40'd1000000},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd1, 40'd1000000, 40'd0,
        1'b1, ST_ADMITTED, 40'd1, 40'd1000001},
      // estimate wider than the load register
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, FULL_SCALE, 40'd1, 40'd0,
        1'b1, ST_REFUSED, 40'd0, 40'd1000001},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, FULL_SCALE, FULL_SCALE, 40'd0,
        1'b1, ST_ADMITTED, 40'd1000000, 40'd2000001},
      '{ROW_REQUEST, 40'd0, REQ_RELEASE, 40'd0, 40'd0, FULL_SCALE,
        1'b1, ST_UNDERFLOW, 40'd0, 40'd2000001},
      '{ROW_REQUEST, 40'd0, REQ_RELEASE, 40'd0, 40'd0, 40'd2000001,
        1'b1, ST_RELEASED, 40'd0, 40'd0},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, FULL_SCALE, 40'd1000000, 40'd0,
        1'b1, ST_REFUSED, 40'd0, 40'd0},
      // fill up to one below full capacity, then hit it exactly
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd1099511, 40'd1, 40'd0,
        1'b1, ST_ADMITTED, 40'd1099511000000, 40'd1099511000000},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd1, 40'd1, 40'd0,
        1'b1, ST_REFUSED, 40'd0, 40'd1099511000000},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd627, 40'd1000, 40'd0,
        1'b1, ST_ADMITTED, 40'd627000, 40'd1099511627000},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd774, 40'd1000000, 40'd0,
        1'b1, ST_ADMITTED, 40'd774, 40'd1099511627774},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd1, 40'd1000000, 40'd0,
        1'b1, ST_REFUSED, 40'd0, 40'd1099511627774},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'hA5A5A5A5A5, 40'h5A5A5A5A5A, 40'h5555555555,
        1'b0, ST_ADMITTED, 40'd0, 40'd0},
      '{ROW_REQUEST, 40'd0, REQ_RELEASE, 40'hAAAAAAAAAA, 40'hAAAAAAAAAA, 40'd1099511627774,
        1'b1, ST_RELEASED, 40'd0, 40'd0},
      '{ROW_CAPACITY, 40'd1000001, REQ_ADMIT, 40'd0, 40'd0, 40'd0,
        1'b0, ST_ADMITTED, 40'd0, 40'd0},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd1, 40'd1, 40'd0,
        1'b1, ST_ADMITTED, 40'd1000000, 40'd1000000},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd1, 40'd1000000, 40'd0,
        1'b1, ST_REFUSED, 40'd0, 40'd1000000},
      '{ROW_REQUEST, 40'd0, REQ_ADMIT, 40'd3, 40'd7, 40'd0,
        1'b0, ST_ADMITTED, 40'd0, 40'd0},
      '{ROW_REQUEST, 40'd0, REQ_RELEASE, 40'd0, 40'd0, 40'd1000000,
        1'b1, ST_RELEASED, 40'd0, 40'd0}
   };

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic load_outcome_type admission_predict(input load_request_type rq);
      load_outcome_type outcome;
      logic [63:0] estimate;
      outcome.granted = '0;
      if (rq.kind == REQ_ADMIT) begin
         if (rq.deadline == '0) begin
            outcome.status = ST_ZERO_DEADLINE;
         end else begin
            estimate = (64'(rq.exec_time) * 64'(GRANULARITY)) / 64'(rq.deadline);
            if (estimate == 64'd0) begin
               outcome.status = ST_ZERO_ESTIMATE;
            end else if (64'(load_model) + estimate >= 64'(capacity_model)) begin
               outcome.status = ST_REFUSED;
            end else begin
               load_model = load_model + estimate[DATA_W-1:0];
               outcome.granted = estimate[DATA_W-1:0];
               outcome.status = ST_ADMITTED;
            end
         end
      end else if (rq.release_amount > load_model) begin
         outcome.status = ST_UNDERFLOW;
      end else begin
         load_model = load_model - rq.release_amount;
         outcome.status = ST_RELEASED;
      end
      outcome.total = load_model;
      return outcome;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t mismatch: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   task automatic send_request(input load_request_type rq, input logic typed,
                               input load_outcome_type fixed);
      load_outcome_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= rq.kind;
      req_bus.exec_time <= rq.exec_time;
      req_bus.deadline <= rq.deadline;
      req_bus.release_amount <= rq.release_amount;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      predicted = admission_predict(rq);
      pending_outcomes.push_back(typed ? fixed : predicted);
   endtask

   task automatic wait_for_outstanding();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_capacity(input logic [DATA_W-1:0] value);
      wait_for_outstanding();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity_model = value;
   endtask

   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      load_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.status !== want.status) begin
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_bus.status, want.status));
            end
            if (rsp_bus.granted_estimate !== want.granted) begin
               report_mismatch($sformatf("granted_estimate got %h want %h",
                                         rsp_bus.granted_estimate, want.granted));
            end
            if (rsp_bus.admitted_total !== want.total) begin
               report_mismatch($sformatf("admitted_total got %h want %h",
                                         rsp_bus.admitted_total, want.total));
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      load_request_type rq;
      load_outcome_type fixed;
      logic [63:0] room;
      logic [63:0] want;
      int unsigned scale;
      int unsigned slack;
      int unsigned roll;
      req_bus.valid <= 1'b0;
      req_bus.req_type <= REQ_ADMIT;
      req_bus.exec_time <= '0;
      req_bus.deadline <= '0;
      req_bus.release_amount <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].row == ROW_CAPACITY) begin
            write_capacity(directed_rows[i].capacity);
         end else begin
            rq = '{directed_rows[i].kind, directed_rows[i].exec_time,
                   directed_rows[i].deadline, directed_rows[i].release_amount};
            fixed = '{directed_rows[i].status, directed_rows[i].granted,
                      directed_rows[i].total};
            send_request(rq, directed_rows[i].typed, fixed);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 49; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 49; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         case (phase)
            0, 5: write_capacity(FULL_SCALE);
            1: write_capacity(40'($urandom_range(1000000, 1 << 30)));
            2: write_capacity('0);
            4: write_capacity(40'd1);
            6: write_capacity(40'(64'(GRANULARITY) * $urandom_range(1, 64)));
            default: write_capacity(40'(random_word()));
         endcase
         repeat (ITEMS_PER_PHASE) begin
            roll = $urandom_range(99);
            rq.kind = REQ_ADMIT;
            rq.exec_time = 40'(random_word());
            rq.deadline = 40'(random_word());
            rq.release_amount = 40'(random_word());
            if (roll < 50) begin
               // admit sized against the remaining headroom
               room = (capacity_model > load_model) ?
                      64'(capacity_model) - 64'(load_model) : 64'd1;
               case ($urandom_range(3))
                  0: want = (room > 64'd1) ? room - 64'd1 : 64'd1;
                  1: want = room;
                  default: want = 64'd1 + random_word() % (room / 64'd16 + 64'd1);
               endcase
               scale = $urandom_range(1, 8);
               if (want * scale + scale > 64'(FULL_SCALE)) begin
                  scale = 1;
               end
               slack = $urandom_range(0, scale - 1);
               rq.exec_time = 40'(want * scale + slack);
               rq.deadline = 40'(64'(GRANULARITY) * scale);
            end else if (roll < 80) begin
               rq.kind = REQ_RELEASE;
               case ($urandom_range(5))
                  0: rq.release_amount = load_model;
                  1: rq.release_amount = load_model + 1'b1;
                  2: rq.release_amount = '0;
                  default: rq.release_amount = 40'(random_word() % (64'(load_model) + 64'd1));
               endcase
            end else if (roll < 85) begin
               rq.deadline = '0;
            end else if (roll < 90) begin
               rq.exec_time = 40'($urandom_range(0, 1000));
               rq.deadline[DATA_W-1] = 1'b1;
            end else begin
               rq.kind = request_kind_type'($urandom_range(1));
               rq.exec_time = rq.exec_time >> $urandom_range(DATA_W - 1);
               rq.deadline = rq.deadline >> $urandom_range(DATA_W - 1);
               rq.release_amount = rq.release_amount >> $urandom_range(DATA_W - 1);
            end
            send_request(rq, 1'b0, '0);
         end
      end

      wait_for_outstanding();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
